// ===== design/sequential_list_engine_defines.svh =====
// Assertion macros shared by the checkers of the sequential list engine.
// Depends on nothing; every macro expects a clock named clk and a reset named rst_n.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, switched off while reset is low.
`define SLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequential_list_engine check failed");

// Next-cycle implication, switched off while reset is low.
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequential_list_engine check failed");

`endif

// ===== design/sle_pkg.sv =====
// Shared types, codes and sizes for the sequential list engine.
// Depends on nothing; the front end, queue, back end, top level and checker refer to it by scoped names.
package sle_pkg;

  localparam int SLE_DEPTH = 1024;
  localparam int SLE_AW    = $clog2(SLE_DEPTH);
  localparam int SLE_CW    = $clog2(SLE_DEPTH + 1);
  localparam int SLE_PW    = 11;
  localparam int SLE_DW    = 32;

  typedef logic [SLE_AW-1:0] sle_addr_t;
  typedef logic [SLE_CW-1:0] sle_cnt_t;
  typedef logic [SLE_PW-1:0] sle_pos_t;
  typedef logic [SLE_DW-1:0] sle_data_t;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_PREPEND = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_SEARCH  = 3'd4;
  localparam logic [2:0] OP_REVERSE = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;
  localparam logic [2:0] OP_CLEAR   = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // Work kinds handed from the front end to the back end.
  localparam logic [2:0] K_DONE    = 3'd0;
  localparam logic [2:0] K_INSERT  = 3'd1;
  localparam logic [2:0] K_DELETE  = 3'd2;
  localparam logic [2:0] K_SEARCH  = 3'd3;
  localparam logic [2:0] K_REVERSE = 3'd4;
  localparam logic [2:0] K_READ    = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] status;
    sle_data_t  value;
    sle_addr_t  idx;
    sle_cnt_t   cnt;
    sle_cnt_t   len;
  } sle_cmd_t;

endpackage

// ===== design/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

// ===== design/sle_front.sv =====
// Front end: accepts items, checks positions against a shadow length and builds commands.
// Depends on sle_pkg.
module sle_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    q_full,
  input  logic [2:0]              in_operation,
  input  logic signed [31:0]      in_value,
  input  sle_pkg::sle_pos_t       in_position,
  output logic                    push,
  output sle_pkg::sle_cmd_t       cmd
);

  sle_pkg::sle_cnt_t count_r, count_nxt;
  logic full;
  logic [31:0] pos_w, cnt_w;

  assign full  = (count_r == sle_pkg::sle_cnt_t'(sle_pkg::SLE_DEPTH));
  assign pos_w = 32'(in_position);
  assign cnt_w = 32'(count_r);
  assign push  = in_valid && !q_full;

  always_comb begin
    cmd        = '0;
    cmd.value  = in_value;
    cmd.cnt    = count_r;
    cmd.len    = count_r;
    cmd.kind   = sle_pkg::K_DONE;
    cmd.status = sle_pkg::ST_OK;
    cmd.idx    = sle_pkg::sle_addr_t'(in_position - 1'b1);
    unique case (in_operation)
      sle_pkg::OP_APPEND, sle_pkg::OP_PREPEND: begin
        if (full) begin
          cmd.status = sle_pkg::ST_FULL;
        end else begin
          cmd.kind = sle_pkg::K_INSERT;
          cmd.idx  = (in_operation == sle_pkg::OP_APPEND) ?
                     sle_pkg::sle_addr_t'(count_r) : '0;
          cmd.len  = count_r + 1'b1;
        end
      end
      sle_pkg::OP_INSERT: begin
        if (pos_w == 32'd0 || pos_w > cnt_w + 32'd1) begin
          cmd.status = sle_pkg::ST_RANGE;
        end else if (full) begin
          cmd.status = sle_pkg::ST_FULL;
        end else begin
          cmd.kind = sle_pkg::K_INSERT;
          cmd.len  = count_r + 1'b1;
        end
      end
      sle_pkg::OP_DELETE, sle_pkg::OP_READ: begin
        if (pos_w == 32'd0 || pos_w > cnt_w) begin
          cmd.status = sle_pkg::ST_RANGE;
        end else if (in_operation == sle_pkg::OP_DELETE) begin
          cmd.kind = sle_pkg::K_DELETE;
          cmd.len  = count_r - 1'b1;
        end else begin
          cmd.kind = sle_pkg::K_READ;
        end
      end
      sle_pkg::OP_SEARCH: begin
        cmd.kind = sle_pkg::K_SEARCH;
      end
      sle_pkg::OP_REVERSE: begin
        if (cnt_w > 32'd1) begin
          cmd.kind = sle_pkg::K_REVERSE;
        end
      end
      sle_pkg::OP_CLEAR: begin
        cmd.len = '0;
      end
      default: begin
        cmd.kind = sle_pkg::K_DONE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = cmd.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/sle_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on sle_pkg.
module sle_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sle_pkg::sle_cmd_t wr_cmd,
  input  logic              pop,
  output sle_pkg::sle_cmd_t head,
  output logic              empty,
  output logic              full
);

  sle_pkg::sle_cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (fill_r == 2'd0);
  assign full  = (fill_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== design/sle_back.sv =====
// Back end: carries out queued commands on the entry RAM and holds the result register.
// Depends on sle_pkg; drives the ports of an sle_ram instance in the top level.
module sle_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sle_pkg::sle_cmd_t      head,
  input  logic                   q_empty,
  output logic                   pop,
  output logic                   mem_we,
  output sle_pkg::sle_addr_t     mem_waddr,
  output sle_pkg::sle_data_t     mem_wdata,
  output sle_pkg::sle_addr_t     mem_raddr,
  input  sle_pkg::sle_data_t     mem_rdata,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic signed [31:0]     out_result_value,
  output sle_pkg::sle_pos_t      out_found_position,
  output sle_pkg::sle_pos_t      out_list_length
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_CHK = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_DEL_RD  = 4'd3;
  localparam logic [3:0] S_DEL_CAP = 4'd4;
  localparam logic [3:0] S_DEL_CHK = 4'd5;
  localparam logic [3:0] S_DEL_WR  = 4'd6;
  localparam logic [3:0] S_SR_CHK  = 4'd7;
  localparam logic [3:0] S_SR_CMP  = 4'd8;
  localparam logic [3:0] S_RV_CHK  = 4'd9;
  localparam logic [3:0] S_RV_A    = 4'd10;
  localparam logic [3:0] S_RV_B    = 4'd11;
  localparam logic [3:0] S_RV_C    = 4'd12;
  localparam logic [3:0] S_RD_RD   = 4'd13;
  localparam logic [3:0] S_RD_CAP  = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0]         state_r, state_nxt;
  sle_pkg::sle_cmd_t  cmd_r, cmd_nxt;
  sle_pkg::sle_cnt_t  i_r, i_nxt, j_r, j_nxt;
  sle_pkg::sle_data_t tmp_r, tmp_nxt, rval_r, rval_nxt;
  logic [1:0]         st_r, st_nxt;
  sle_pkg::sle_pos_t  fpos_r, fpos_nxt;
  logic               ov_r, ov_nxt;
  logic [1:0]         os_r, os_nxt;
  sle_pkg::sle_data_t oval_r, oval_nxt;
  sle_pkg::sle_pos_t  opos_r, opos_nxt, olen_r, olen_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    tmp_nxt   = tmp_r;
    rval_nxt  = rval_r;
    st_nxt    = st_r;
    fpos_nxt  = fpos_r;
    ov_nxt    = ov_r && out_stall;
    os_nxt    = os_r;
    oval_nxt  = oval_r;
    opos_nxt  = opos_r;
    olen_nxt  = olen_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sle_pkg::sle_addr_t'(i_r);
    mem_wdata = mem_rdata;
    mem_raddr = sle_pkg::sle_addr_t'(i_r);
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          cmd_nxt  = head;
          st_nxt   = head.status;
          rval_nxt = '0;
          fpos_nxt = '0;
          i_nxt    = '0;
          unique case (head.kind)
            sle_pkg::K_INSERT: begin
              i_nxt     = head.cnt;
              state_nxt = S_INS_CHK;
            end
            sle_pkg::K_DELETE:  state_nxt = S_DEL_RD;
            sle_pkg::K_SEARCH:  state_nxt = S_SR_CHK;
            sle_pkg::K_REVERSE: begin
              j_nxt     = head.cnt - 1'b1;
              state_nxt = S_RV_CHK;
            end
            sle_pkg::K_READ:    state_nxt = S_RD_RD;
            default:            state_nxt = S_EMIT;
          endcase
        end
      end
      S_INS_CHK: begin
        if (i_r > sle_pkg::sle_cnt_t'(cmd_r.idx)) begin
          mem_raddr = sle_pkg::sle_addr_t'(i_r - 1'b1);
          state_nxt = S_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cmd_r.idx;
          mem_wdata = cmd_r.value;
          state_nxt = S_EMIT;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        i_nxt     = i_r - 1'b1;
        state_nxt = S_INS_CHK;
      end
      S_DEL_RD: begin
        mem_raddr = cmd_r.idx;
        state_nxt = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        rval_nxt  = mem_rdata;
        i_nxt     = sle_pkg::sle_cnt_t'(cmd_r.idx) + 1'b1;
        state_nxt = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        state_nxt = (i_r < cmd_r.cnt) ? S_DEL_WR : S_EMIT;
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sle_pkg::sle_addr_t'(i_r - 1'b1);
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DEL_CHK;
      end
      S_SR_CHK: begin
        if (i_r < cmd_r.cnt) begin
          state_nxt = S_SR_CMP;
        end else begin
          st_nxt    = sle_pkg::ST_MISS;
          state_nxt = S_EMIT;
        end
      end
      S_SR_CMP: begin
        if (mem_rdata == cmd_r.value) begin
          fpos_nxt  = sle_pkg::sle_pos_t'(i_r + 1'b1);
          state_nxt = S_EMIT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SR_CHK;
        end
      end
      S_RV_CHK: begin
        state_nxt = (i_r < j_r) ? S_RV_A : S_EMIT;
      end
      S_RV_A: begin
        tmp_nxt   = mem_rdata;
        mem_raddr = sle_pkg::sle_addr_t'(j_r);
        state_nxt = S_RV_B;
      end
      S_RV_B: begin
        mem_we    = 1'b1;
        state_nxt = S_RV_C;
      end
      S_RV_C: begin
        mem_we    = 1'b1;
        mem_waddr = sle_pkg::sle_addr_t'(j_r);
        mem_wdata = tmp_r;
        i_nxt     = i_r + 1'b1;
        j_nxt     = j_r - 1'b1;
        state_nxt = S_RV_CHK;
      end
      S_RD_RD: begin
        mem_raddr = cmd_r.idx;
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        rval_nxt  = mem_rdata;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          os_nxt    = st_r;
          oval_nxt  = rval_r;
          opos_nxt  = fpos_r;
          olen_nxt  = sle_pkg::sle_pos_t'(cmd_r.len);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    tmp_r  <= tmp_nxt;
    rval_r <= rval_nxt;
    st_r   <= st_nxt;
    fpos_r <= fpos_nxt;
    os_r   <= os_nxt;
    oval_r <= oval_nxt;
    opos_r <= opos_nxt;
    olen_r <= olen_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_result_value   = oval_r;
  assign out_found_position = opos_r;
  assign out_list_length    = olen_r;

endmodule

// ===== design/sequential_list_engine.sv =====
// Sequential list engine: an ordered list of signed 32-bit values kept in a RAM of 1024
// entries with a length count. Each input beat carries one operation (append, prepend,
// insert, delete, search, reverse, read or clear) and produces exactly one result beat
// with a status, a value, a position and the new length, in order. A front end checks
// positions and fullness against its own copy of the length and queues a command; a back
// end then walks the RAM, which has one write and one registered read port. Append,
// read, clear and every rejected operation need no walk over the entries. Insert and
// delete move each trailing entry with one read and one write; search reads and compares
// the entries one at a time; reverse reads both entries of each swapped pair and writes
// them back in swapped places. That RAM walk sets the throughput. The two-deep queue and
// the result register let new beats be taken while a result waits. No clearing pass is
// needed after reset, as only entries below the length are ever read.
module sequential_list_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_operation,
  input  logic signed [31:0]  in_value,
  input  logic [10:0]         in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_result_value,
  output logic [10:0]         out_found_position,
  output logic [10:0]         out_list_length
);

  sle_pkg::sle_cmd_t  front_cmd, q_head;
  logic               push, pop, q_empty, q_full;
  logic               mem_we;
  sle_pkg::sle_addr_t mem_waddr, mem_raddr;
  sle_pkg::sle_data_t mem_wdata, mem_rdata;

  // The input side stalls only when the command queue is full.
  assign in_stall = q_full;

  sle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .q_full       (q_full),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .push         (push),
    .cmd          (front_cmd)
  );

  sle_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  sle_ram #(
    .WIDTH (sle_pkg::SLE_DW),
    .DEPTH (sle_pkg::SLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sle_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_empty            (q_empty),
    .pop                (pop),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_value   (out_result_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

endmodule

// ===== design/sle_checker.sv =====
// Port-level checker for the sequential list engine, bound to the top level.
// Depends on sle_pkg and sequential_list_engine_defines.svh.
`include "sequential_list_engine_defines.svh"

module sle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_result_value,
  input logic [10:0]        out_found_position,
  input logic [10:0]        out_list_length
);

  `SLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SLE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_result_value))
  `SLE_ASSERT_SAME(a_full_len, out_valid && out_status == sle_pkg::ST_FULL, 32'(out_list_length) == sle_pkg::SLE_DEPTH)
  `SLE_ASSERT_SAME(a_found_ok, out_valid && out_found_position != 11'd0, out_status == sle_pkg::ST_OK)
  `SLE_ASSERT_SAME(a_miss_zero, out_valid && out_status == sle_pkg::ST_MISS, out_found_position == 11'd0 && out_result_value == 32'sd0)

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_result_value   (out_result_value),
  .out_found_position (out_found_position),
  .out_list_length    (out_list_length)
);
